// ===== rtl/cln_pkg.sv =====
// Shared types, codes and constant tables for the character display sequencer.
// No dependencies; every other source file depends on this package.
`timescale 1ns / 1ps

package cln_pkg;

    // Opcodes of an input transaction
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_VWRITE  = 3'd1;
    localparam logic [2:0] OP_REFRESH = 3'd2;
    localparam logic [2:0] OP_CMD     = 3'd3;
    localparam logic [2:0] OP_INIT    = 3'd4;
    localparam logic [2:0] OP_DATA    = 3'd5;
    localparam logic [2:0] OP_CURSOR  = 3'd6;

    // Configuration register indexes
    localparam logic REG_STROBE = 1'b0;
    localparam logic REG_PAUSE  = 1'b1;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [3:0] INIT_NIBBLE = 4'h3;
    // Last step of the init schedule that strobes or waits
    localparam logic [3:0] INIT_LAST_WAIT_STEP = 4'd6;
    localparam logic [3:0] INIT_FIRST_CMD_STEP = 4'd7;
    localparam logic [3:0] INIT_LAST_CMD_STEP  = 4'd11;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_INIT_WAIT,
        PH_INIT_GAP,
        PH_INIT_HIGH,
        PH_ONE_GAP,
        PH_ONE_HIGH,
        PH_REF_GAP,
        PH_REF_HIGH
    } t_phase;

    typedef struct packed {
        logic [2:0] opcode;
        logic [5:0] video_address;
        logic [7:0] byte_value;
        logic [2:0] cursor_line;
        logic [4:0] cursor_column;
    } t_in_item;

    typedef struct packed {
        logic       register_select;
        logic       rw_pin;
        logic       enable_pin;
        logic [3:0] data_nibble;
        logic       busy_res;
        logic       accepted;
    } t_out_item;

    // Request from the sequencer to the video store
    typedef struct packed {
        logic       we;
        logic [5:0] waddr;
        logic [7:0] wdata;
        logic [6:0] raddr;
    } t_store_req;

    function automatic logic [7:0] line_base(input logic [1:0] line);
        logic [7:0] b;
        case (line)
            2'd0: b = 8'h80;
            2'd1: b = 8'hC0;
            2'd2: b = 8'h90;
            default: b = 8'hD0;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] init_wait(input logic [1:0] idx);
        logic [15:0] w;
        case (idx)
            2'd0: w = 16'd400;
            2'd1: w = 16'd400;
            2'd2: w = 16'd200;
            default: w = 16'd100;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h32;
            3'd1: c = 8'h28;
            3'd2: c = 8'h0C;
            3'd3: c = 8'h01;
            3'd4: c = 8'h06;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/cln_in_if.sv =====
// Input channel: valid/ready handshake carrying one request transaction.
// Depends on cln_pkg for the payload type.
`timescale 1ns / 1ps

interface cln_in_if;
    logic              valid;
    logic              ready;
    cln_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cln_out_if.sv =====
// Output channel: valid/ready handshake carrying one result transaction.
// Depends on cln_pkg for the payload type.
`timescale 1ns / 1ps

interface cln_out_if;
    logic               valid;
    logic               ready;
    cln_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cln_video_store.sv =====
// Video store: two-port synchronous RAM with per-entry valid bits and a
// write-to-read bypass. Depends on cln_pkg.
`timescale 1ns / 1ps

module cln_video_store #(
    parameter int VIDEO_BYTES = 60
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cln_pkg::t_store_req i_req,
    output logic [7:0]          o_char
);
    import cln_pkg::*;

    localparam int AW = (VIDEO_BYTES > 1) ? $clog2(VIDEO_BYTES) : 1;

    logic [7:0]             r_mem [VIDEO_BYTES];
    logic [VIDEO_BYTES-1:0] r_vld;
    logic [7:0]             r_q;
    logic [7:0]             r_fwd_data;
    logic                   r_fwd;
    logic                   r_ok;
    logic                   r_vld_rd;

    logic [AW-1:0] rd_idx;
    logic [AW-1:0] wr_idx;
    logic          rd_ok;

    assign rd_idx = i_req.raddr[AW-1:0];
    assign wr_idx = i_req.waddr[AW-1:0];
    assign rd_ok  = (i_req.raddr < 7'(VIDEO_BYTES));

    // Write the requested entry, read the prefetch address
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[wr_idx] <= i_req.wdata;
        end
        r_q        <= r_mem[rd_idx];
        r_fwd_data <= i_req.wdata;
    end

    // Track written entries; unwritten ones read as a space
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_fwd    <= 1'b0;
            r_ok     <= 1'b0;
            r_vld_rd <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[wr_idx] <= 1'b1;
            end
            r_fwd    <= i_req.we && (wr_idx == rd_idx);
            r_ok     <= rd_ok;
            r_vld_rd <= rd_ok ? r_vld[rd_idx] : 1'b0;
        end
    end

    // Bypass a write that hit the address read in the same cycle
    always_comb begin
        if (!r_ok) begin
            o_char = CHAR_SPACE;
        end else if (r_fwd) begin
            o_char = r_fwd_data;
        end else if (r_vld_rd) begin
            o_char = r_q;
        end else begin
            o_char = CHAR_SPACE;
        end
    end

endmodule

// ===== rtl/cln_sequencer.sv =====
// Pin sequencer: phase machine for init, single bytes and refresh, plus the
// configuration registers. Drives the video store. Depends on cln_pkg.
`timescale 1ns / 1ps

module cln_sequencer #(
    parameter int LINES       = 4,
    parameter int COLUMNS     = 15,
    parameter int VIDEO_BYTES = 60
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  cln_pkg::t_in_item    i_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic [7:0]           i_char,
    output cln_pkg::t_store_req  o_req,
    output cln_pkg::t_out_item   o_res
);
    import cln_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_step, n_step;
    logic [15:0] r_wait, n_wait;
    logic [7:0]  r_cur, n_cur;
    logic        r_low, n_low;
    logic [1:0]  r_line, n_line;
    logic [3:0]  r_col, n_col;
    logic        r_rs, n_rs;
    logic        r_e, n_e;
    logic [3:0]  r_nib, n_nib;
    logic [7:0]  r_strobe;
    logic [15:0] r_pause;

    logic        acc;
    logic        run_init;
    logic        ref_next;
    logic        ref_send;
    logic        idle;
    logic [15:0] dec_wait;
    logic [15:0] strobe_load;
    logic [15:0] pause_load;
    logic [7:0]  ref_byte;
    logic [1:0]  p_line;
    logic [3:0]  p_col;
    logic [3:0]  p_step;
    logic [6:0]  p_ptr;

    assign idle        = (r_phase == PH_IDLE);
    assign dec_wait    = (r_wait != 16'd0) ? (r_wait - 16'd1) : 16'd0;
    assign strobe_load = (r_strobe != 8'd0) ? {8'd0, r_strobe} : 16'd1;
    assign pause_load  = (r_pause != 16'd0) ? r_pause : 16'd1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 8'd1;
            r_pause  <= 16'd2;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_STROBE) begin
                r_strobe <= i_cfg_data[7:0];
            end else begin
                r_pause <= i_cfg_data;
            end
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_step  <= 4'd0;
            r_wait  <= 16'd0;
            r_cur   <= 8'd0;
            r_low   <= 1'b0;
            r_line  <= 2'd0;
            r_col   <= 4'd0;
            r_rs    <= 1'b0;
            r_e     <= 1'b0;
            r_nib   <= 4'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_wait  <= n_wait;
            r_cur   <= n_cur;
            r_low   <= n_low;
            r_line  <= n_line;
            r_col   <= n_col;
            r_rs    <= n_rs;
            r_e     <= n_e;
            r_nib   <= n_nib;
        end
    end

    // Next state for one transaction
    always_comb begin
        n_phase   = r_phase;
        n_step    = r_step;
        n_wait    = r_wait;
        n_cur     = r_cur;
        n_low     = r_low;
        n_line    = r_line;
        n_col     = r_col;
        n_rs      = r_rs;
        n_e       = r_e;
        n_nib     = r_nib;
        acc       = 1'b0;
        run_init  = 1'b0;
        ref_next  = 1'b0;
        ref_send  = 1'b0;
        ref_byte  = 8'd0;

        // Decode the request or advance one tick
        case (i_item.opcode)
            OP_TICK: begin
                case (r_phase)
                    PH_INIT_WAIT: begin
                        n_wait = dec_wait;
                        if (dec_wait == 16'd0) begin
                            n_step   = r_step + 4'd1;
                            run_init = 1'b1;
                        end
                    end
                    PH_INIT_GAP, PH_ONE_GAP, PH_REF_GAP: begin
                        n_e    = 1'b1;
                        n_wait = strobe_load;
                        case (r_phase)
                            PH_INIT_GAP: n_phase = PH_INIT_HIGH;
                            PH_ONE_GAP:  n_phase = PH_ONE_HIGH;
                            default:     n_phase = PH_REF_HIGH;
                        endcase
                    end
                    PH_INIT_HIGH, PH_ONE_HIGH, PH_REF_HIGH: begin
                        n_wait = dec_wait;
                        if (dec_wait == 16'd0) begin
                            n_e = 1'b0;
                            if (r_low) begin
                                // Put the low nibble out with E low
                                n_low = 1'b0;
                                n_nib = r_cur[3:0];
                                case (r_phase)
                                    PH_INIT_HIGH: n_phase = PH_INIT_GAP;
                                    PH_ONE_HIGH:  n_phase = PH_ONE_GAP;
                                    default:      n_phase = PH_REF_GAP;
                                endcase
                            end else if (r_phase == PH_INIT_HIGH) begin
                                if (r_step < INIT_FIRST_CMD_STEP) begin
                                    n_step   = r_step + 4'd1;
                                    run_init = 1'b1;
                                end else begin
                                    n_wait  = pause_load;
                                    n_phase = PH_INIT_WAIT;
                                end
                            end else if (r_phase == PH_REF_HIGH) begin
                                ref_next = 1'b1;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            OP_VWRITE: begin
                acc = ({1'b0, i_item.video_address} < 7'(VIDEO_BYTES));
            end
            OP_REFRESH: begin
                if (idle) begin
                    n_line   = 2'd0;
                    n_col    = 4'd0;
                    n_step   = 4'd0;
                    ref_send = 1'b1;
                    acc      = 1'b1;
                end
            end
            OP_CMD, OP_DATA: begin
                if (idle) begin
                    n_rs    = (i_item.opcode == OP_DATA);
                    n_cur   = i_item.byte_value;
                    n_low   = 1'b1;
                    n_nib   = i_item.byte_value[7:4];
                    n_e     = 1'b0;
                    n_phase = PH_ONE_GAP;
                    acc     = 1'b1;
                end
            end
            OP_INIT: begin
                if (idle) begin
                    n_step   = 4'd0;
                    run_init = 1'b1;
                    acc      = 1'b1;
                end
            end
            OP_CURSOR: begin
                if (idle && !i_item.cursor_line[2] && !i_item.cursor_column[4]) begin
                    n_rs    = 1'b0;
                    n_cur   = line_base(i_item.cursor_line[1:0])
                              + {4'd0, i_item.cursor_column[3:0]};
                    n_low   = 1'b1;
                    n_nib   = n_cur[7:4];
                    n_e     = 1'b0;
                    n_phase = PH_ONE_GAP;
                    acc     = 1'b1;
                end
            end
            default: ;
        endcase

        // Run the init schedule step in n_step
        if (run_init) begin
            if (n_step <= INIT_LAST_WAIT_STEP) begin
                if (!n_step[0]) begin
                    n_e     = 1'b0;
                    n_wait  = init_wait(n_step[2:1]);
                    n_phase = PH_INIT_WAIT;
                end else begin
                    n_rs    = 1'b0;
                    n_low   = 1'b0;
                    n_nib   = INIT_NIBBLE;
                    n_e     = 1'b0;
                    n_phase = PH_INIT_GAP;
                end
            end else if (n_step <= INIT_LAST_CMD_STEP) begin
                n_rs    = 1'b0;
                n_cur   = init_cmd(3'(n_step - INIT_FIRST_CMD_STEP));
                n_low   = 1'b1;
                n_nib   = n_cur[7:4];
                n_e     = 1'b0;
                n_phase = PH_INIT_GAP;
            end else begin
                n_phase = PH_IDLE;
            end
        end

        // Advance the refresh position
        if (ref_next) begin
            if (r_step == 4'd0) begin
                n_step   = 4'd1;
                n_col    = 4'd0;
                ref_send = 1'b1;
            end else if ({1'b0, r_col} + 5'd1 < 5'(COLUMNS)) begin
                n_col    = r_col + 4'd1;
                ref_send = 1'b1;
            end else if ({1'b0, r_line} + 3'd1 < 3'(LINES)) begin
                n_line   = r_line + 2'd1;
                n_col    = 4'd0;
                n_step   = 4'd0;
                ref_send = 1'b1;
            end else begin
                n_phase = PH_IDLE;
            end
        end

        // Start a cursor byte or a prefetched character
        if (ref_send) begin
            if (n_step == 4'd0) begin
                n_rs     = 1'b0;
                ref_byte = line_base(n_line);
            end else begin
                n_rs     = 1'b1;
                ref_byte = i_char;
            end
            n_cur   = ref_byte;
            n_low   = 1'b1;
            n_nib   = ref_byte[7:4];
            n_e     = 1'b0;
            n_phase = PH_REF_GAP;
        end
    end

    // Prefetch address: the next character refresh will send
    always_comb begin
        p_line = i_accept ? n_line : r_line;
        p_col  = i_accept ? n_col  : r_col;
        p_step = i_accept ? n_step : r_step;
        p_ptr  = 7'(p_line) * 7'(COLUMNS)
                 + ((p_step == 4'd0) ? 7'd0 : (7'(p_col) + 7'd1));
    end

    assign o_req.we    = i_accept && (i_item.opcode == OP_VWRITE) && acc;
    assign o_req.waddr = i_item.video_address;
    assign o_req.wdata = i_item.byte_value;
    assign o_req.raddr = p_ptr;

    assign o_res.register_select = n_rs;
    assign o_res.rw_pin          = 1'b0;
    assign o_res.enable_pin      = n_e;
    assign o_res.data_nibble     = n_nib;
    assign o_res.busy_res        = (n_phase != PH_IDLE);
    assign o_res.accepted        = acc;

endmodule

// ===== rtl/char_lcd_nibble_sequencer_core.sv =====
// Output: the result of an accepted request is registered in the output register.
// Throughput: one transaction per cycle unless the output stalls; the sequencer handles
// a tick or request in one step; the store is read ahead at the next refresh position.
// Reset: synchronous, active low; control state and registers clear at once, the video
// store reads as spaces through per-entry valid bits, with no clearing pass.
// Depends on cln_pkg, cln_in_if, cln_out_if, cln_sequencer and cln_video_store.
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_core #(
    parameter int LINES       = 4,
    parameter int COLUMNS     = 15,
    parameter int VIDEO_BYTES = 60
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cln_in_if.sink         i_in,
    cln_out_if.source      o_out,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [15:0]    i_cfg_data
);
    import cln_pkg::*;

    logic       in_accept;
    t_store_req store_req;
    t_out_item  seq_res;
    logic [7:0] store_char;
    logic       r_out_valid;
    t_out_item  r_out_data;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    cln_sequencer #(
        .LINES       (LINES),
        .COLUMNS     (COLUMNS),
        .VIDEO_BYTES (VIDEO_BYTES)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_item     (i_in.data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_char     (store_char),
        .o_req      (store_req),
        .o_res      (seq_res)
    );

    cln_video_store #(
        .VIDEO_BYTES (VIDEO_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_char  (store_char)
    );

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= seq_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

// ===== rtl/cln_checker.sv =====
// Port-level checks on the sequencer core, attached by bind.
// Depends on cln_pkg and char_lcd_nibble_sequencer_core.
`timescale 1ns / 1ps

module cln_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input cln_pkg::t_out_item i_out_data
);
    import cln_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // Every accepted transaction shows a result in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted transaction gave no result");

    // E is low whenever the sequencer is idle
    a_idle_e_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.busy_res |-> !i_out_data.enable_pin)
        else $error("enable high while idle");

    // RW never leaves write
    a_rw_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_out_data.rw_pin)
        else $error("RW pin driven high");

    // Reset drops the result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind char_lcd_nibble_sequencer_core cln_checker u_cln_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ===== tb/sv/char_lcd_nibble_sequencer_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for char_lcd_nibble_sequencer_core: a queue-fed driver sends request
// transactions, a monitor checks every pin-level result against an in-bench predictor.
// Depends on cln_pkg, cln_in_if, cln_out_if and the core RTL.

module char_lcd_nibble_sequencer_core_tb;
    import cln_pkg::*;

    localparam int ROWS         = 4;
    localparam int COLS         = 15;
    localparam int VRAM_DEPTH   = 60;
    localparam int MAX_LINE     = 3;
    localparam int MAX_COLUMN   = 15;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int GAP_MAX      = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS  = 10;
    localparam int RAND_ITEMS   = 30;
    localparam int INIT_TICKS   = 24;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct {
        t_in_item    item;
        int unsigned gap;
    } t_lcd_req;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = REG_STROBE;
    logic [15:0] i_cfg_data = '0;

    cln_in_if  in_ch ();
    cln_out_if out_ch ();

    char_lcd_nibble_sequencer_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Pending requests and the pin levels they are predicted to produce
    t_lcd_req    req_q [$];
    t_out_item   pins_q [$];

    int          err_cnt   = 0;
    int          n_results = 0;
    int          cycle_cnt = 0;
    bit          calm      = 1'b0;
    bit          hold_req  = 1'b0;
    logic        hold_off  = 1'b0;
    int unsigned src_gap   = 0;
    bit          src_armed = 1'b0;
    int unsigned snk_gap   = 0;
    bit          snk_armed = 1'b0;

    // Predicted display controller state
    logic [7:0]  lcd_vram [VRAM_DEPTH];
    t_phase      lcd_phase;
    logic [3:0]  lcd_step;
    logic [15:0] lcd_wait;
    logic [7:0]  lcd_byte;
    logic        lcd_low_pend;
    logic [1:0]  lcd_row;
    logic [3:0]  lcd_col;
    logic        lcd_rs;
    logic        lcd_e;
    logic [3:0]  lcd_nib;
    logic [7:0]  cfg_strobe;
    logic [15:0] cfg_pause;

    always #5 i_clk = ~i_clk;

    // DDRAM set-address command for column 0 of a display line
    function automatic logic [7:0] row_addr_cmd(input logic [1:0] row);
        case (row)
            2'd0: return 8'h80;
            2'd1: return 8'hC0;
            2'd2: return 8'h90;
            default: return 8'hD0;
        endcase
    endfunction

    function automatic logic [7:0] boot_cmd(input logic [3:0] idx);
        case (idx)
            4'd0: return 8'h32;
            4'd1: return 8'h28;
            4'd2: return 8'h0C;
            4'd3: return 8'h01;
            default: return 8'h06;
        endcase
    endfunction

    function automatic logic [15:0] boot_wait(input logic [1:0] idx);
        case (idx)
            2'd0, 2'd1: return 16'd400;
            2'd2: return 16'd200;
            default: return 16'd100;
        endcase
    endfunction

    function automatic void lcd_reset();
        for (int i = 0; i < VRAM_DEPTH; i++) lcd_vram[i] = CHAR_SPACE;
        lcd_phase    = PH_IDLE;
        lcd_step     = '0;
        lcd_wait     = '0;
        lcd_byte     = '0;
        lcd_low_pend = 1'b0;
        lcd_row      = '0;
        lcd_col      = '0;
        lcd_rs       = 1'b0;
        lcd_e        = 1'b0;
        lcd_nib      = '0;
        cfg_strobe   = 8'd1;
        cfg_pause    = 16'd2;
    endfunction

    // Put the high nibble of a byte on the bus with E low
    function automatic void lcd_start_byte(input logic [7:0] b, input t_phase gap);
        lcd_byte     = b;
        lcd_low_pend = 1'b1;
        lcd_nib      = b[7:4];
        lcd_e        = 1'b0;
        lcd_phase    = gap;
    endfunction

    function automatic void lcd_start_wait(input logic [15:0] n);
        lcd_e     = 1'b0;
        lcd_wait  = (n == 16'd0) ? 16'd1 : n;
        lcd_phase = PH_INIT_WAIT;
    endfunction

    // Advance the power-on schedule to its current step
    function automatic void lcd_boot_next();
        if (lcd_step <= INIT_LAST_WAIT_STEP) begin
            if (!lcd_step[0]) begin
                lcd_start_wait(boot_wait(lcd_step[2:1]));
            end else begin
                lcd_rs       = 1'b0;
                lcd_low_pend = 1'b0;
                lcd_nib      = INIT_NIBBLE;
                lcd_e        = 1'b0;
                lcd_phase    = PH_INIT_GAP;
            end
        end else if (lcd_step <= INIT_LAST_CMD_STEP) begin
            lcd_rs = 1'b0;
            lcd_start_byte(boot_cmd(lcd_step - INIT_FIRST_CMD_STEP), PH_INIT_GAP);
        end else begin
            lcd_phase = PH_IDLE;
        end
    endfunction

    function automatic void lcd_refresh_send();
        int addr;
        if (lcd_step == 4'd0) begin
            lcd_rs = 1'b0;
            lcd_start_byte(row_addr_cmd(lcd_row), PH_REF_GAP);
        end else begin
            addr   = int'(lcd_row) * COLS + int'(lcd_col);
            lcd_rs = 1'b1;
            lcd_start_byte((addr < VRAM_DEPTH) ? lcd_vram[addr] : CHAR_SPACE, PH_REF_GAP);
        end
    endfunction

    function automatic void lcd_refresh_next();
        if (lcd_step == 4'd0) begin
            lcd_step = 4'd1;
            lcd_col  = '0;
            lcd_refresh_send();
        end else if (int'(lcd_col) + 1 < COLS) begin
            lcd_col = lcd_col + 4'd1;
            lcd_refresh_send();
        end else if (int'(lcd_row) + 1 < ROWS) begin
            lcd_row  = lcd_row + 2'd1;
            lcd_col  = '0;
            lcd_step = '0;
            lcd_refresh_send();
        end else begin
            lcd_phase = PH_IDLE;
        end
    endfunction

    function automatic void lcd_strobe_done();
        if (lcd_phase == PH_INIT_HIGH) begin
            if (lcd_step < INIT_FIRST_CMD_STEP) begin
                lcd_step = lcd_step + 4'd1;
                lcd_boot_next();
            end else begin
                lcd_start_wait(cfg_pause);
            end
        end else if (lcd_phase == PH_REF_HIGH) begin
            lcd_refresh_next();
        end else begin
            lcd_phase = PH_IDLE;
        end
    endfunction

    // One time tick of the pin sequencer
    function automatic void lcd_tick();
        case (lcd_phase)
            PH_INIT_WAIT: begin
                if (lcd_wait != 16'd0) lcd_wait = lcd_wait - 16'd1;
                if (lcd_wait == 16'd0) begin
                    lcd_step = lcd_step + 4'd1;
                    lcd_boot_next();
                end
            end
            PH_INIT_GAP, PH_ONE_GAP, PH_REF_GAP: begin
                lcd_e    = 1'b1;
                lcd_wait = (cfg_strobe == 8'd0) ? 16'd1 : {8'd0, cfg_strobe};
                case (lcd_phase)
                    PH_INIT_GAP: lcd_phase = PH_INIT_HIGH;
                    PH_ONE_GAP:  lcd_phase = PH_ONE_HIGH;
                    default:     lcd_phase = PH_REF_HIGH;
                endcase
            end
            PH_INIT_HIGH, PH_ONE_HIGH, PH_REF_HIGH: begin
                if (lcd_wait != 16'd0) lcd_wait = lcd_wait - 16'd1;
                if (lcd_wait == 16'd0) begin
                    lcd_e = 1'b0;
                    if (lcd_low_pend) begin
                        lcd_low_pend = 1'b0;
                        lcd_nib      = lcd_byte[3:0];
                        case (lcd_phase)
                            PH_INIT_HIGH: lcd_phase = PH_INIT_GAP;
                            PH_ONE_HIGH:  lcd_phase = PH_ONE_GAP;
                            default:      lcd_phase = PH_REF_GAP;
                        endcase
                    end else begin
                        lcd_strobe_done();
                    end
                end
            end
            default: lcd_phase = PH_IDLE;
        endcase
    endfunction

    // Apply one request transaction and return the pin levels it leaves behind
    function automatic t_out_item lcd_predict(input t_in_item it);
        logic      idle;
        logic      acc;
        t_out_item r;
        idle = (lcd_phase == PH_IDLE);
        acc  = 1'b0;
        case (it.opcode)
            OP_TICK: lcd_tick();
            OP_VWRITE: begin
                if (int'(it.video_address) < VRAM_DEPTH) begin
                    lcd_vram[it.video_address] = it.byte_value;
                    acc = 1'b1;
                end
            end
            OP_REFRESH: begin
                if (idle) begin
                    lcd_row  = '0;
                    lcd_col  = '0;
                    lcd_step = '0;
                    lcd_refresh_send();
                    acc = 1'b1;
                end
            end
            OP_CMD, OP_DATA: begin
                if (idle) begin
                    lcd_rs = (it.opcode == OP_DATA);
                    lcd_start_byte(it.byte_value, PH_ONE_GAP);
                    acc = 1'b1;
                end
            end
            OP_INIT: begin
                if (idle) begin
                    lcd_step = '0;
                    lcd_boot_next();
                    acc = 1'b1;
                end
            end
            OP_CURSOR: begin
                if (idle && it.cursor_line <= MAX_LINE && it.cursor_column <= MAX_COLUMN) begin
                    lcd_rs = 1'b0;
                    lcd_start_byte(row_addr_cmd(it.cursor_line[1:0])
                                   + {4'd0, it.cursor_column[3:0]}, PH_ONE_GAP);
                    acc = 1'b1;
                end
            end
            default: ;
        endcase
        r.register_select = lcd_rs;
        r.rw_pin          = 1'b0;
        r.enable_pin      = lcd_e;
        r.data_nibble     = lcd_nib;
        r.busy_res        = (lcd_phase != PH_IDLE);
        r.accepted        = acc;
        return r;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.opcode        = 3'($urandom_range(0, 7));
        it.video_address = 6'($urandom_range(0, 63));
        it.byte_value    = 8'($urandom_range(0, 255));
        it.cursor_line   = 3'($urandom_range(0, 7));
        it.cursor_column = 5'($urandom_range(0, 31));
        return it;
    endfunction

    // Queue a request and record its predicted result
    task automatic queue_item(input t_in_item it);
        t_lcd_req r;
        r.item = it;
        r.gap  = calm ? 0 : $urandom_range(0, GAP_MAX);
        req_q.push_back(r);
        pins_q.push_back(lcd_predict(it));
    endtask

    task automatic queue_op(input logic [2:0] op, input logic [5:0] addr,
                            input logic [7:0] val, input logic [2:0] line,
                            input logic [4:0] col);
        t_in_item it;
        it.opcode        = op;
        it.video_address = addr;
        it.byte_value    = val;
        it.cursor_line   = line;
        it.cursor_column = col;
        queue_item(it);
    endtask

    task automatic queue_tick();
        t_in_item it;
        it        = rand_item();
        it.opcode = OP_TICK;
        queue_item(it);
    endtask

    // Feed ticks until the predicted sequencer goes idle
    task automatic queue_ticks_to_idle();
        while (lcd_phase != PH_IDLE) queue_tick();
    endtask

    // Feed ticks until idle, with store writes and refused requests mixed in
    task automatic queue_busy_mix();
        t_in_item it;
        while (lcd_phase != PH_IDLE) begin
            it = rand_item();
            if ($urandom_range(0, 15) != 0) it.opcode = OP_TICK;
            else if ($urandom_range(0, 1) == 0) it.opcode = OP_VWRITE;
            queue_item(it);
        end
    endtask

    // Random traffic: mostly ticks while a sequence runs, short requests while idle
    task automatic queue_random(input int budget);
        int          n;
        int unsigned pick;
        t_in_item    it;
        n = 0;
        while (n < budget) begin
            it   = rand_item();
            pick = $urandom_range(0, 99);
            if (lcd_phase != PH_IDLE) begin
                if (pick < 85) it.opcode = OP_TICK;
            end else if (pick < 20) begin
                it.opcode = OP_TICK;
            end else if (pick < 40) begin
                it.opcode = OP_VWRITE;
            end else if (pick < 58) begin
                it.opcode = OP_CMD;
            end else if (pick < 76) begin
                it.opcode = OP_DATA;
            end else if (pick < 94) begin
                it.opcode = OP_CURSOR;
                if ($urandom_range(0, 3) != 0) begin
                    it.cursor_line   = 3'($urandom_range(0, MAX_LINE));
                    it.cursor_column = 5'($urandom_range(0, MAX_COLUMN));
                end
            end else begin
                it.opcode = OP_UNUSED;
            end
            queue_item(it);
            if (it.opcode == OP_TICK || pins_q[$].accepted) n++;
        end
        queue_ticks_to_idle();
    endtask

    // Hold the sender until every predicted result has been checked
    task automatic wait_drained();
        while (req_q.size() != 0 || pins_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_STROBE) cfg_strobe = value[7:0];
        else cfg_pause = value;
    endtask

    task automatic check_pins(input t_out_item got);
        t_out_item want;
        if (pins_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("result %0d arrived with no pending transaction: %p", n_results, got);
        end else begin
            want = pins_q.pop_front();
            if (got.register_select !== want.register_select ||
                got.rw_pin !== want.rw_pin ||
                got.enable_pin !== want.enable_pin ||
                got.data_nibble !== want.data_nibble ||
                got.busy_res !== want.busy_res ||
                got.accepted !== want.accepted) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("result %0d: expected rs=%b rw=%b e=%b db=%h busy=%b acc=%b",
                             n_results, want.register_select, want.rw_pin,
                             want.enable_pin, want.data_nibble, want.busy_res,
                             want.accepted,
                             ", got rs=%b rw=%b e=%b db=%h busy=%b acc=%b",
                             got.register_select, got.rw_pin,
                             got.enable_pin, got.data_nibble, got.busy_res, got.accepted);
            end
        end
        n_results++;
    endtask

    // Driver: offer the oldest pending request after its drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            src_armed = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                void'(req_q.pop_front());
                src_armed = 1'b0;
            end
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (req_q.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else begin
                    if (!src_armed) begin
                        src_gap   = req_q[0].gap;
                        src_armed = 1'b1;
                    end
                    if (src_gap != 0) begin
                        src_gap--;
                        in_ch.valid <= 1'b0;
                    end else begin
                        in_ch.valid <= 1'b1;
                        in_ch.data  <= req_q[0].item;
                    end
                end
            end
        end
    end

    // Monitor: check each result transaction, with a randomly drawn stall between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            snk_armed = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_pins(out_ch.data);
                snk_armed = 1'b0;
            end
            if (!snk_armed) begin
                snk_gap   = calm ? 0 : $urandom_range(0, GAP_MAX);
                snk_armed = 1'b1;
            end
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else if (snk_gap != 0) begin
                snk_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so the core backs up and stalls its input
    initial begin
        wait (hold_req);
        repeat (20) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Abort a run that stops making progress
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        lcd_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle tick, store writes at both ends and past the end, unused opcode
        queue_op(OP_TICK, 6'd0, 8'h00, 3'd0, 5'd0);
        queue_op(OP_VWRITE, 6'd0, 8'h00, 3'd0, 5'd0);
        queue_op(OP_VWRITE, 6'd59, 8'hFF, 3'd7, 5'd31);
        queue_op(OP_VWRITE, 6'd60, 8'h41, 3'd0, 5'd0);
        queue_op(OP_VWRITE, 6'd63, 8'h42, 3'd0, 5'd0);
        queue_op(OP_UNUSED, 6'd63, 8'hFF, 3'd7, 5'd31);
        // Out-of-range cursor targets are dropped
        queue_op(OP_CURSOR, 6'd0, 8'h00, 3'd4, 5'd0);
        queue_op(OP_CURSOR, 6'd0, 8'h00, 3'd0, 5'd16);
        queue_op(OP_CURSOR, 6'd0, 8'h00, 3'd7, 5'd31);
        // Last cursor position, then requests while busy; store writes still land
        queue_op(OP_CURSOR, 6'd0, 8'h00, 3'd3, 5'd15);
        queue_tick();
        queue_op(OP_CMD, 6'd0, 8'hFF, 3'd0, 5'd0);
        queue_op(OP_VWRITE, 6'd30, 8'h7E, 3'd0, 5'd0);
        queue_ticks_to_idle();
        queue_op(OP_CMD, 6'd0, 8'hFF, 3'd0, 5'd0);
        queue_tick();
        queue_op(OP_REFRESH, 6'd0, 8'h00, 3'd0, 5'd0);
        queue_op(OP_INIT, 6'd0, 8'h00, 3'd0, 5'd0);
        queue_op(OP_DATA, 6'd0, 8'h55, 3'd0, 5'd0);
        queue_ticks_to_idle();
        queue_op(OP_DATA, 6'd0, 8'h00, 3'd0, 5'd0);
        queue_ticks_to_idle();
        queue_op(OP_CURSOR, 6'd0, 8'h00, 3'd0, 5'd0);
        queue_ticks_to_idle();

        // Zero registers act as one; refresh with store writes mixed in, long hold-off
        write_reg(REG_STROBE, 16'h5A00);
        write_reg(REG_PAUSE, 16'h0000);
        queue_op(OP_REFRESH, 6'd0, 8'h00, 3'd0, 5'd0);
        queue_busy_mix();
        hold_req = 1'b1;
        wait_drained();

        // Random traffic with longer strobes
        write_reg(REG_STROBE, 16'd3);
        write_reg(REG_PAUSE, 16'hFFFF);
        queue_random(RAND_ITEMS);
        wait_drained();

        // Random traffic with no idling on either side
        calm = 1'b1;
        write_reg(REG_STROBE, 16'd1);
        write_reg(REG_PAUSE, 16'd2);
        queue_random(RAND_ITEMS);
        wait_drained();
        calm = 1'b0;

        // Start init and tick into its first wait; a command is refused meanwhile, a store write lands
        queue_op(OP_INIT, 6'd0, 8'h00, 3'd0, 5'd0);
        repeat (INIT_TICKS) queue_tick();
        queue_op(OP_CMD, 6'd0, 8'h01, 3'd0, 5'd0);
        queue_op(OP_VWRITE, 6'd5, 8'h61, 3'd0, 5'd0);
        queue_tick();
        wait_drained();

        if (err_cnt == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cln_pkg.sv
rtl/cln_in_if.sv
rtl/cln_out_if.sv
rtl/cln_video_store.sv
rtl/cln_sequencer.sv
rtl/char_lcd_nibble_sequencer_core.sv
rtl/cln_checker.sv
tb/sv/char_lcd_nibble_sequencer_core_tb.sv
